// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the valve angle calculator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge of clk, suspended while rst_n is low
`define OLVA_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Same-cycle implication checked on every rising edge of clk
`define OLVA_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/olva_pkg.sv =====
// Package: constants, lookup tables and register codes of the valve angle calculator
`timescale 1ns / 1ps

package olva_pkg;

    // Table sizes
    localparam int DENSITY_POINTS = 20;
    localparam int VALVE_POINTS   = 16;

    // Datapath widths of the shared serial units
    localparam int MUL_W   = 32;
    localparam int SQRT_RW = 48;
    localparam int DIV_NW  = 48;
    localparam int DIV_DW  = 24;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_OX_ANGLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMBIENT  = 2'd1;

    // Register reset values
    localparam logic [14:0] OX_ANGLE_RESET = 15'd12800;
    localparam logic [15:0] AMBIENT_RESET  = 16'd941;

    // Fixed-point coefficients
    localparam logic [14:0] ANGLE_MAX      = 15'd23040;
    localparam logic [31:0] DROP_COEF      = 32'd404223741;
    localparam logic [31:0] CV_COEF        = 32'd68122070;
    localparam logic [23:0] CV_FLOOR_ROOT  = 24'd5243;
    localparam logic [31:0] OX_FLOW_COEF   = 32'd72029923;
    localparam logic [31:0] FUEL_FLOW_COEF = 32'd11154986;

    // Oxidizer density against temperature (K*16 -> Q24 lb/in^3)
    localparam int DENS_TEMP [DENSITY_POINTS] = '{
        880, 960, 1040, 1120, 1200, 1280, 1360, 1440, 1520, 1600,
        1680, 1760, 1840, 1920, 2000, 2080, 2160, 2240, 2320, 2400};
    localparam int DENS_VAL [DENSITY_POINTS] = '{
        790044, 777043, 763519, 749742, 735761, 721556, 707080, 692245, 676982, 661205,
        644787, 627612, 609514, 590271, 569581, 547007, 521861, 492918, 457694, 409420};

    // Fuel valve Cv (Q16) against angle (deg*256)
    localparam int CV_PTS [VALVE_POINTS] = '{
        0, 5289, 5322, 5322, 5322, 7766, 13533, 23324,
        37657, 56590, 79587, 105428, 132075, 156533, 174758, 181528};
    localparam int ANG_PTS [VALVE_POINTS] = '{
        0, 1536, 3072, 4608, 6144, 7680, 9216, 10752,
        12288, 13824, 15360, 16896, 18432, 19968, 21504, 23040};

endpackage

// ===== rtl/core/olva_mul.sv =====
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps

module olva_mul #(
    parameter int W = olva_pkg::MUL_W
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           start,
    input  logic [W-1:0]   a,
    input  logic [W-1:0]   b,
    output logic           done,
    output logic [2*W-1:0] prod
);

    localparam int CW = $clog2(W + 1);

    logic           run_reg, run_next;
    logic           done_reg, done_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [W-1:0]   a_reg;
    logic [W-1:0]   b_reg;
    logic [2*W-1:0] acc_reg;
    logic [W:0]     sum;

    // Partial product added into the upper half, then shifted down
    assign sum = {1'b0, acc_reg[2*W-1:W]} + {1'b0, (b_reg[0] ? a_reg : {W{1'b0}})};

    // Step control
    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand and accumulator shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (run_reg)
        begin
            acc_reg <= {sum, acc_reg[W-1:1]};
            b_reg   <= {1'b0, b_reg[W-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule

// ===== rtl/core/olva_sqrt.sv =====
// Digit-serial integer square root, two radicand bits per cycle
`timescale 1ns / 1ps

module olva_sqrt #(
    parameter int RW = olva_pkg::SQRT_RW
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  logic [RW-1:0]   radicand,
    output logic            done,
    output logic [RW/2-1:0] root
);

    localparam int RH = RW / 2;
    localparam int CW = $clog2(RH + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [RW-1:0] rad_reg;
    logic [RH+1:0] rem_reg;
    logic [RH-1:0] root_reg;
    logic [RH+3:0] cur;
    logic [RH+3:0] trial;
    logic [RH+3:0] diff;
    logic          ge;

    // Bring down the next two bits and try root*4+1
    assign cur   = {rem_reg, rad_reg[RW-1:RW-2]};
    assign trial = {2'b00, root_reg, 2'b01};
    assign ge    = cur >= trial;
    assign diff  = cur - trial;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(RH - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Radicand, partial remainder and root shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (run_reg)
        begin
            rad_reg  <= {rad_reg[RW-3:0], 2'b00};
            rem_reg  <= ge ? diff[RH+1:0] : cur[RH+1:0];
            root_reg <= {root_reg[RH-2:0], ge};
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== rtl/core/olva_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module olva_div #(
    parameter int NW = olva_pkg::DIV_NW,
    parameter int DW = olva_pkg::DIV_DW
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    input  logic [DW-1:0] divisor,
    output logic          done,
    output logic [NW-1:0] quotient
);

    localparam int CW = $clog2(NW + 1);

    logic          run_reg, run_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [NW-1:0] quo_reg;
    logic [DW-1:0] rem_reg;
    logic [DW-1:0] den_reg;
    logic [DW:0]   cur;
    logic [DW:0]   diff;
    logic          ge;

    // Shift in the next dividend bit and trial-subtract the divisor
    assign cur  = {rem_reg, quo_reg[NW-1]};
    assign ge   = cur >= {1'b0, den_reg};
    assign diff = cur - {1'b0, den_reg};

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = '0;
        end
        else if (run_reg)
        begin
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(NW - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[NW-2:0], ge};
            rem_reg <= ge ? diff[DW-1:0] : cur[DW-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/core/open_loop_valve_angle_calc_unit.sv =====
// Top level: sequencer over shared serial multiplier, square root and divider
// Steps: 8 multiplies, 3 roots and 3 divides, each started from the launch state; busy is
//   high from the accepted start until done.
// A new tick is not taken while one is in work; a new start is taken in the cycle done is shown.
// The single serial units work one bit (two for the root) per cycle.
// done strobes for one cycle with the results; the receiver cannot stall.
// Reset is asynchronous, active low: idle, registers at 12800 and 941.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module open_loop_valve_angle_calc_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // Command side
    input  logic                           start,
    output logic                           busy,
    input  logic [15:0]                    fuel_flow_target,
    input  logic [15:0]                    fuel_upstream_pressure,
    input  logic signed [15:0]             ox_venturi_dp,
    input  logic [11:0]                    ox_venturi_temp,
    input  logic signed [15:0]             fuel_venturi_dp,
    // Configuration writes
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [olva_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]                    cfg_data,
    // Results
    output logic                           done,
    output logic [14:0]                    ox_angle,
    output logic [14:0]                    fuel_angle,
    output logic [15:0]                    downstream_goal,
    output logic [15:0]                    measured_ox_flow,
    output logic [15:0]                    measured_fuel_flow
);

    localparam int VIW = $clog2(olva_pkg::VALVE_POINTS);
    localparam int DIW = $clog2(olva_pkg::DENSITY_POINTS);

    // Sequencer states
    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_LAUNCH = 2'd1;
    localparam logic [1:0] ST_WAIT   = 2'd2;

    // Operation steps, in order
    localparam logic [3:0] OP_MM   = 4'd0;
    localparam logic [3:0] OP_DROP = 4'd1;
    localparam logic [3:0] OP_ROOT = 4'd2;
    localparam logic [3:0] OP_NUM  = 4'd3;
    localparam logic [3:0] OP_CV   = 4'd4;
    localparam logic [3:0] OP_VT   = 4'd5;
    localparam logic [3:0] OP_VQ   = 4'd6;
    localparam logic [3:0] OP_DT   = 4'd7;
    localparam logic [3:0] OP_DQ   = 4'd8;
    localparam logic [3:0] OP_RD   = 4'd9;
    localparam logic [3:0] OP_SOX  = 4'd10;
    localparam logic [3:0] OP_OXF  = 4'd11;
    localparam logic [3:0] OP_SFU  = 4'd12;
    localparam logic [3:0] OP_FUF  = 4'd13;

    // Control registers
    logic [1:0]  state_reg, state_next;
    logic [3:0]  op_reg, op_next;
    logic        done_reg, done_next;
    logic [14:0] ox_set_reg;
    logic [15:0] amb_reg;

    // Latched inputs and intermediate results
    logic [15:0] m_reg;
    logic [15:0] up_reg;
    logic [15:0] oxdp_reg;
    logic [11:0] temp_reg;
    logic [15:0] fdp_reg;
    logic [31:0] mm_reg;
    logic [24:0] goal_reg;
    logic [23:0] root_reg;
    logic [43:0] num_reg;
    logic [31:0] cv_reg;
    logic [31:0] tp_reg;
    logic [14:0] fang_reg;
    logic [19:0] rho_reg;
    logic [34:0] rd_reg;
    logic [23:0] sox_reg;
    logic [23:0] sfu_reg;
    logic [15:0] oxf_reg;
    logic [14:0] ox_angle_reg;
    logic [14:0] fuel_angle_reg;
    logic [15:0] goal_out_reg;
    logic [15:0] oxf_out_reg;
    logic [15:0] fuf_out_reg;

    // Shared unit connections
    logic        mul_start, sq_start, dv_start;
    logic        mul_done, sq_done, dv_done;
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_prod;
    logic [47:0] sq_rad;
    logic [23:0] sq_root;
    logic [47:0] dv_num;
    logic [23:0] dv_den;
    logic [47:0] dv_quo;
    logic        unit_done;
    logic        accept;

    // Derived values
    logic [63:0] prod_rnd40;
    logic [63:0] prod_rnd32;
    logic        up_gt;
    logic [15:0] valve_dp;
    logic [15:0] flow_sat;

    // Valve table lookup
    logic [VIW-1:0] v_idx;
    logic           v_below, v_above;
    logic [31:0]    v_t, v_span, v_mag, v_res;
    logic signed [31:0] v_dy;

    // Density table lookup
    logic [DIW-1:0] d_idx;
    logic           d_below, d_above;
    logic [31:0]    d_t, d_span, d_mag, d_res;
    logic signed [31:0] d_dy;

    assign accept    = start && !busy;
    assign busy      = state_reg != ST_IDLE;
    assign cfg_ready = 1'b1;
    assign unit_done = mul_done || sq_done || dv_done;

    // Shared arithmetic units
    olva_mul #(.W(olva_pkg::MUL_W)) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    olva_sqrt #(.RW(olva_pkg::SQRT_RW)) u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (sq_rad),
        .done     (sq_done),
        .root     (sq_root)
    );

    olva_div #(.NW(olva_pkg::DIV_NW), .DW(olva_pkg::DIV_DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (dv_start),
        .dividend (dv_num),
        .divisor  (dv_den),
        .done     (dv_done),
        .quotient (dv_quo)
    );

    // Rounded product slices and saturation
    assign prod_rnd40 = mul_prod + 64'h0000_0080_0000_0000;
    assign prod_rnd32 = mul_prod + 64'h0000_0000_8000_0000;
    assign flow_sat   = (|prod_rnd32[63:48]) ? 16'hFFFF : prod_rnd32[47:32];
    assign up_gt      = {9'd0, up_reg} > goal_reg;
    assign valve_dp   = up_reg - goal_reg[15:0];

    // Valve interval search: last breakpoint not above Cv
    always_comb
    begin
        v_idx = '0;
        for (int k = 0; k < olva_pkg::VALVE_POINTS - 1; k++)
        begin
            if (cv_reg >= 32'(olva_pkg::CV_PTS[k]))
                v_idx = VIW'(k);
        end
    end

    assign v_below = cv_reg < 32'(olva_pkg::CV_PTS[0]);
    assign v_above = cv_reg >= 32'(olva_pkg::CV_PTS[olva_pkg::VALVE_POINTS-1]);
    assign v_t     = cv_reg - 32'(olva_pkg::CV_PTS[v_idx]);
    assign v_span  = 32'(olva_pkg::CV_PTS[v_idx + 1'b1]) - 32'(olva_pkg::CV_PTS[v_idx]);
    assign v_dy    = 32'(olva_pkg::ANG_PTS[v_idx + 1'b1]) - 32'(olva_pkg::ANG_PTS[v_idx]);
    assign v_mag   = v_dy[31] ? 32'(-v_dy) : 32'(v_dy);

    // Valve result: clamp at the ends, else base plus or minus rounded step
    always_comb
    begin
        priority if (v_below)
            v_res = 32'(olva_pkg::ANG_PTS[0]);
        else if (v_above)
            v_res = 32'(olva_pkg::ANG_PTS[olva_pkg::VALVE_POINTS-1]);
        else if (v_dy[31])
            v_res = 32'(olva_pkg::ANG_PTS[v_idx]) - dv_quo[31:0];
        else
            v_res = 32'(olva_pkg::ANG_PTS[v_idx]) + dv_quo[31:0];
    end

    // Density interval search on temperature
    always_comb
    begin
        d_idx = '0;
        for (int k = 0; k < olva_pkg::DENSITY_POINTS - 1; k++)
        begin
            if ({20'd0, temp_reg} >= 32'(olva_pkg::DENS_TEMP[k]))
                d_idx = DIW'(k);
        end
    end

    assign d_below = {20'd0, temp_reg} < 32'(olva_pkg::DENS_TEMP[0]);
    assign d_above = {20'd0, temp_reg} >=
                     32'(olva_pkg::DENS_TEMP[olva_pkg::DENSITY_POINTS-1]);
    assign d_t     = {20'd0, temp_reg} - 32'(olva_pkg::DENS_TEMP[d_idx]);
    assign d_span  = 32'(olva_pkg::DENS_TEMP[d_idx + 1'b1]) -
                     32'(olva_pkg::DENS_TEMP[d_idx]);
    assign d_dy    = 32'(olva_pkg::DENS_VAL[d_idx + 1'b1]) - 32'(olva_pkg::DENS_VAL[d_idx]);
    assign d_mag   = d_dy[31] ? 32'(-d_dy) : 32'(d_dy);

    always_comb
    begin
        priority if (d_below)
            d_res = 32'(olva_pkg::DENS_VAL[0]);
        else if (d_above)
            d_res = 32'(olva_pkg::DENS_VAL[olva_pkg::DENSITY_POINTS-1]);
        else if (d_dy[31])
            d_res = 32'(olva_pkg::DENS_VAL[d_idx]) - dv_quo[31:0];
        else
            d_res = 32'(olva_pkg::DENS_VAL[d_idx]) + dv_quo[31:0];
    end

    // Operand selection per step
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        sq_rad = '0;
        dv_num = '0;
        dv_den = '0;
        unique case (op_reg)
            OP_MM:
            begin
                mul_a = {16'd0, m_reg};
                mul_b = {16'd0, m_reg};
            end
            OP_DROP:
            begin
                mul_a = mm_reg;
                mul_b = olva_pkg::DROP_COEF;
            end
            OP_ROOT: sq_rad = {valve_dp, 32'd0};
            OP_NUM:
            begin
                mul_a = {16'd0, m_reg};
                mul_b = olva_pkg::CV_COEF;
            end
            OP_CV:
            begin
                dv_num = {4'd0, num_reg} + {25'd0, root_reg[23:1]};
                dv_den = root_reg;
            end
            OP_VT:
            begin
                mul_a = v_t;
                mul_b = v_mag;
            end
            OP_VQ:
            begin
                dv_num = {16'd0, tp_reg} + {17'd0, v_span[31:1]};
                dv_den = v_span[23:0];
            end
            OP_DT:
            begin
                mul_a = d_t;
                mul_b = d_mag;
            end
            OP_DQ:
            begin
                dv_num = {16'd0, tp_reg} + {17'd0, d_span[31:1]};
                dv_den = d_span[23:0];
            end
            OP_RD:
            begin
                mul_a = {12'd0, rho_reg};
                mul_b = {16'd0, oxdp_reg};
            end
            OP_SOX: sq_rad = {5'd0, rd_reg, 8'd0};
            OP_OXF:
            begin
                mul_a = {8'd0, sox_reg};
                mul_b = olva_pkg::OX_FLOW_COEF;
            end
            OP_SFU: sq_rad = {fdp_reg, 32'd0};
            OP_FUF:
            begin
                mul_a = {8'd0, sfu_reg};
                mul_b = olva_pkg::FUEL_FLOW_COEF;
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // Unit launch by step kind
    always_comb
    begin
        mul_start = 1'b0;
        sq_start  = 1'b0;
        dv_start  = 1'b0;
        if (state_reg == ST_LAUNCH)
        begin
            unique case (op_reg)
                OP_ROOT, OP_SOX, OP_SFU: sq_start  = 1'b1;
                OP_CV, OP_VQ, OP_DQ:     dv_start  = 1'b1;
                default:                 mul_start = 1'b1;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        done_next  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LAUNCH;
                    op_next    = OP_MM;
                end
            end
            ST_LAUNCH: state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (unit_done)
                begin
                    if (op_reg == OP_FUF)
                    begin
                        state_next = ST_IDLE;
                        done_next  = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_LAUNCH;
                        op_next    = op_reg + 1'b1;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            op_reg     <= OP_MM;
            done_reg   <= 1'b0;
            ox_set_reg <= olva_pkg::OX_ANGLE_RESET;
            amb_reg    <= olva_pkg::AMBIENT_RESET;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            done_reg  <= done_next;
            // Configuration transfer
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == olva_pkg::CFG_OX_ANGLE)
                    ox_set_reg <= cfg_data[14:0];
                else if (cfg_index == olva_pkg::CFG_AMBIENT)
                    amb_reg <= cfg_data;
            end
        end
    end

    // Input capture, negative venturi readings clamped to zero
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_reg    <= fuel_flow_target;
            up_reg   <= fuel_upstream_pressure;
            oxdp_reg <= ox_venturi_dp[15] ? 16'd0 : ox_venturi_dp;
            temp_reg <= ox_venturi_temp;
            fdp_reg  <= fuel_venturi_dp[15] ? 16'd0 : fuel_venturi_dp;
        end
    end

    // Result capture at the end of each step
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_WAIT && unit_done)
        begin
            unique case (op_reg)
                OP_MM:   mm_reg   <= mul_prod[31:0];
                OP_DROP: goal_reg <= {9'd0, amb_reg} + {1'b0, prod_rnd40[63:40]};
                OP_ROOT: root_reg <= up_gt ? sq_root : olva_pkg::CV_FLOOR_ROOT;
                OP_NUM:  num_reg  <= mul_prod[43:0];
                OP_CV:   cv_reg   <= dv_quo[31:0];
                OP_VT:   tp_reg   <= mul_prod[31:0];
                OP_VQ:   fang_reg <= v_res[14:0];
                OP_DT:   tp_reg   <= mul_prod[31:0];
                OP_DQ:   rho_reg  <= d_res[19:0];
                OP_RD:   rd_reg   <= mul_prod[34:0];
                OP_SOX:  sox_reg  <= sq_root;
                OP_OXF:  oxf_reg  <= flow_sat;
                OP_SFU:  sfu_reg  <= sq_root;
                OP_FUF:
                begin
                    ox_angle_reg   <= (ox_set_reg > olva_pkg::ANGLE_MAX) ?
                                      olva_pkg::ANGLE_MAX : ox_set_reg;
                    fuel_angle_reg <= fang_reg;
                    goal_out_reg   <= (|goal_reg[24:16]) ? 16'hFFFF : goal_reg[15:0];
                    oxf_out_reg    <= oxf_reg;
                    fuf_out_reg    <= flow_sat;
                end
                default: mm_reg <= mm_reg;
            endcase
        end
    end

    assign done               = done_reg;
    assign ox_angle           = ox_angle_reg;
    assign fuel_angle         = fuel_angle_reg;
    assign downstream_goal    = goal_out_reg;
    assign measured_ox_flow   = oxf_out_reg;
    assign measured_fuel_flow = fuf_out_reg;

    // Checks
    `OLVA_ASSERT_IMP(a_done_idle, done, !busy, "result shown while still busy")
    `OLVA_ASSERT(a_done_pulse, done |=> !done, "done held for more than one cycle")
    `OLVA_ASSERT(a_accept_busy, accept |=> busy, "accepted command did not raise busy")
    `OLVA_ASSERT_IMP(a_unit_one, state_reg == ST_WAIT,
        $countones({mul_done, sq_done, dv_done}) <= 1, "two units finished together")
    `OLVA_ASSERT_IMP(a_angle_rng, done,
        fuel_angle <= olva_pkg::ANGLE_MAX && ox_angle <= olva_pkg::ANGLE_MAX,
        "angle beyond full travel")

endmodule

// ===== sim/open_loop_valve_angle_calc_unit_test.sv =====
// Self-checking testbench for the open-loop valve angle calculator
`timescale 1ns / 1ps

module open_loop_valve_angle_calc_unit_test;

    typedef struct packed {
        logic [14:0] ox_ang;
        logic [14:0] fuel_ang;
        logic [15:0] goal;
        logic [15:0] ox_flow;
        logic [15:0] fuel_flow;
    } valve_cmd_t;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic                           busy;
    logic [15:0]                    fuel_flow_target;
    logic [15:0]                    fuel_upstream_pressure;
    logic signed [15:0]             ox_venturi_dp;
    logic [11:0]                    ox_venturi_temp;
    logic signed [15:0]             fuel_venturi_dp;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [olva_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [15:0]                    cfg_data;
    logic                           done;
    logic [14:0]                    ox_angle;
    logic [14:0]                    fuel_angle;
    logic [15:0]                    downstream_goal;
    logic [15:0]                    measured_ox_flow;
    logic [15:0]                    measured_fuel_flow;

    // Model copy of the registers
    logic [14:0] ox_setting_q;
    logic [15:0] ambient_q;

    valve_cmd_t  pending_cmds[$];
    int          mismatches;
    bit          no_idle;

    open_loop_valve_angle_calc_unit dut (
        .clk                    (clk),
        .rst_n                  (rst_n),
        .start                  (start),
        .busy                   (busy),
        .fuel_flow_target       (fuel_flow_target),
        .fuel_upstream_pressure (fuel_upstream_pressure),
        .ox_venturi_dp          (ox_venturi_dp),
        .ox_venturi_temp        (ox_venturi_temp),
        .fuel_venturi_dp        (fuel_venturi_dp),
        .cfg_valid              (cfg_valid),
        .cfg_ready              (cfg_ready),
        .cfg_index              (cfg_index),
        .cfg_data               (cfg_data),
        .done                   (done),
        .ox_angle               (ox_angle),
        .fuel_angle             (fuel_angle),
        .downstream_goal        (downstream_goal),
        .measured_ox_flow       (measured_ox_flow),
        .measured_fuel_flow     (measured_fuel_flow)
    );

    // Clock: 4 ns period
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // Integer square root, floor
    function automatic longint unsigned int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return r;
    endfunction

    // Clamped piecewise-linear lookup; sel picks density (1) or valve (0) table
    function automatic longint interp(longint v, bit sel);
        longint xs[olva_pkg::DENSITY_POINTS];
        longint ys[olva_pkg::DENSITY_POINTS];
        int     n;
        longint t;
        longint span;
        longint dy;
        if (sel)
        begin
            n = olva_pkg::DENSITY_POINTS;
            for (int i = 0; i < olva_pkg::DENSITY_POINTS; i++)
            begin
                xs[i] = olva_pkg::DENS_TEMP[i];
                ys[i] = olva_pkg::DENS_VAL[i];
            end
        end
        else
        begin
            n = olva_pkg::VALVE_POINTS;
            for (int i = 0; i < olva_pkg::VALVE_POINTS; i++)
            begin
                xs[i] = olva_pkg::CV_PTS[i];
                ys[i] = olva_pkg::ANG_PTS[i];
            end
        end
        if (v < xs[0])
            return ys[0];
        for (int i = 0; i + 1 < n; i++)
        begin
            if (xs[i] <= v && v < xs[i+1])
            begin
                t    = v - xs[i];
                span = xs[i+1] - xs[i];
                dy   = ys[i+1] - ys[i];
                if (dy >= 0)
                    return ys[i] + (t * dy + span / 2) / span;
                return ys[i] - (t * (-dy) + span / 2) / span;
            end
        end
        return ys[n-1];
    endfunction

    function automatic logic [15:0] sat16(longint unsigned v);
        return (v > 65535) ? 16'hFFFF : v[15:0];
    endfunction

    // Valve command for one tick
    function automatic valve_cmd_t valve_cmd(logic [15:0] m_in, logic [15:0] up_in,
                                             logic [15:0] oxdp_in, logic [11:0] temp_in,
                                             logic [15:0] fudp_in);
        valve_cmd_t      c;
        longint unsigned m;
        longint unsigned up;
        longint unsigned oxdp;
        longint unsigned fudp;
        longint unsigned drop;
        longint unsigned goal;
        longint unsigned root;
        longint unsigned cv;
        longint unsigned rho;
        longint unsigned oxf;
        longint unsigned fuf;
        longint          ang;
        m    = m_in;
        up   = up_in;
        oxdp = oxdp_in[15] ? 0 : oxdp_in;
        fudp = fudp_in[15] ? 0 : fudp_in;
        drop = (m * m * olva_pkg::DROP_COEF + (64'd1 << 39)) >> 40;
        goal = ambient_q + drop;
        // pressure delta floored at a tiny positive value
        root = (up > goal) ? int_sqrt((up - goal) << 32) : olva_pkg::CV_FLOOR_ROOT;
        cv   = (m * olva_pkg::CV_COEF + root / 2) / root;
        ang  = interp(longint'(cv), 1'b0);
        rho  = interp(longint'(temp_in), 1'b1);
        oxf  = (olva_pkg::OX_FLOW_COEF * int_sqrt((rho * oxdp) << 8) + (64'd1 << 31)) >> 32;
        fuf  = (olva_pkg::FUEL_FLOW_COEF * int_sqrt(fudp << 32) + (64'd1 << 31)) >> 32;
        c.ox_ang    = (ox_setting_q > olva_pkg::ANGLE_MAX) ? olva_pkg::ANGLE_MAX :
                      ox_setting_q;
        c.fuel_ang  = ang[14:0];
        c.goal      = sat16(goal);
        c.ox_flow   = sat16(oxf);
        c.fuel_flow = sat16(fuf);
        return c;
    endfunction

    // Result checker: done cannot be held off
    always @(posedge clk)
    begin
        valve_cmd_t want;
        valve_cmd_t got;
        if (rst_n && done)
        begin
            got = '{ox_angle, fuel_angle, downstream_goal, measured_ox_flow,
                    measured_fuel_flow};
            if (pending_cmds.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h at %0t", got, $realtime);
            end
            else
            begin
                want = pending_cmds.pop_front();
                if (want != got)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: exp ox %0d fa %0d g %0d of %0d ff %0d",
                                  " / got ox %0d fa %0d g %0d of %0d ff %0d"},
                                 want.ox_ang, want.fuel_ang, want.goal, want.ox_flow,
                                 want.fuel_flow, got.ox_ang, got.fuel_ang, got.goal,
                                 got.ox_flow, got.fuel_flow);
                end
            end
        end
    end

    // One tick transfer
    task automatic send_tick(logic [15:0] m, logic [15:0] up, logic [15:0] oxdp,
                             logic [11:0] temp, logic [15:0] fudp);
        int gap;
        gap = no_idle ? 0 : int'($urandom_range(0, 9));
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        fuel_flow_target       <= m;
        fuel_upstream_pressure <= up;
        ox_venturi_dp          <= oxdp;
        ox_venturi_temp        <= temp;
        fuel_venturi_dp        <= fudp;
        start                  <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_cmds.push_back(valve_cmd(m, up, oxdp, temp, fudp));
    endtask

    // Wait for every result to be back, then let the block settle
    task automatic drain();
        @(posedge clk);
        start <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [olva_pkg::CFG_IDX_W-1:0] idx, logic [15:0] val);
        drain();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == olva_pkg::CFG_OX_ANGLE)
            ox_setting_q = val[14:0];
        else if (idx == olva_pkg::CFG_AMBIENT)
            ambient_q = val;
    endtask

    // Random tick, mostly plausible operating points
    task automatic send_random_tick();
        logic [15:0] m;
        logic [15:0] up;
        logic [15:0] oxdp;
        logic [15:0] fudp;
        logic [11:0] temp;
        int          mode;
        mode = int'($urandom_range(0, 9));
        m    = (mode < 6) ? 16'($urandom_range(0, 6000)) : 16'($urandom);
        up   = 16'($urandom);
        if (mode < 4)
            up = 16'($urandom_range(32'(ambient_q), 65535));
        oxdp = (mode == 9) ? 16'($urandom) : 16'($urandom_range(0, 32767));
        fudp = (mode == 8) ? 16'($urandom) : 16'($urandom_range(0, 32767));
        temp = (mode < 7) ? 12'($urandom_range(800, 2500)) : 12'($urandom);
        send_tick(m, up, oxdp, temp, fudp);
    endtask

    task automatic test_directed();
        no_idle = 1'b0;
        send_tick(16'd0, 16'd0, 16'h8000, 12'd0, 16'h8000);
        send_tick(16'hFFFF, 16'hFFFF, 16'h7FFF, 12'hFFF, 16'h7FFF);
        send_tick(16'd0, 16'hFFFF, 16'hFFFF, 12'd879, 16'hFFFF);
        send_tick(16'd1000, 16'd0, 16'd0, 12'd880, 16'd0);
        send_tick(16'd1000, 16'd941, 16'd1, 12'd2400, 16'd1);
        send_tick(16'd1000, 16'd942, 16'd6400, 12'd2399, 16'd6400);
        send_tick(16'd3000, 16'd20000, 16'd12800, 12'd1000, 16'd3200);
        send_tick(16'd4096, 16'd30000, 16'h5555, 12'hAAA, 16'h2AAA);
        send_tick(16'hAAAA, 16'h5555, 16'hAAAA, 12'h555, 16'hD555);
        send_tick(16'h5555, 16'hAAAA, 16'h7000, 12'd1500, 16'h6000);
        send_tick(16'd200, 16'd1000, 16'd100, 12'd2000, 16'd100);
        send_tick(16'd500, 16'd960, 16'd32767, 12'd880, 16'd32767);
        send_tick(16'd2500, 16'd65535, 16'd20000, 12'd1200, 16'd20000);
        drain();
    endtask

    // Register extremes, including oversized oxidizer angle and unused indexes
    task automatic test_config_sweep();
        logic [15:0] ox_vals[6]  = '{16'd0, 16'd23040, 16'd23041, 16'h7FFF,
                                     16'hFFFF, 16'd12800};
        logic [15:0] amb_vals[6] = '{16'd0, 16'hFFFF, 16'd941, 16'd30000, 16'd65000,
                                     16'd941};
        for (int p = 0; p < 6; p++)
        begin
            write_reg(olva_pkg::CFG_OX_ANGLE, ox_vals[p]);
            write_reg(olva_pkg::CFG_AMBIENT, amb_vals[p]);
            write_reg(2'd2, 16'($urandom));
            write_reg(2'd3, 16'($urandom));
            for (int i = 0; i < 60; i++)
                send_random_tick();
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(olva_pkg::CFG_OX_ANGLE, 16'($urandom_range(0, 32767)));
            write_reg(olva_pkg::CFG_AMBIENT,
                      (ph % 3 == 0) ? 16'd941 : 16'($urandom_range(0, 4000)));
            for (int i = 0; i < 140; i++)
            begin
                if (i % 35 == 0)
                    no_idle = ($urandom_range(0, 2) == 0);
                send_random_tick();
            end
            no_idle = 1'b0;
        end
    endtask

    // Sender holds off until every result is back, then resumes
    task automatic test_pause();
        for (int i = 0; i < 40; i++)
        begin
            send_random_tick();
            if (i % 10 == 9)
                drain();
        end
    endtask

    initial
    begin
        rst_n                  = 1'b0;
        start                  = 1'b0;
        fuel_flow_target       = '0;
        fuel_upstream_pressure = '0;
        ox_venturi_dp          = '0;
        ox_venturi_temp        = '0;
        fuel_venturi_dp        = '0;
        cfg_valid              = 1'b0;
        cfg_index              = '0;
        cfg_data               = '0;
        ox_setting_q           = olva_pkg::OX_ANGLE_RESET;
        ambient_q              = olva_pkg::AMBIENT_RESET;
        mismatches             = 0;
        no_idle                = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_config_sweep();
        test_random();
        test_pause();

        drain();
        repeat (600) @(posedge clk);
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog
    initial
    begin
        #30_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/olva_pkg.sv
rtl/core/olva_mul.sv
rtl/core/olva_sqrt.sv
rtl/core/olva_div.sv
rtl/core/open_loop_valve_angle_calc_unit.sv
sim/open_loop_valve_angle_calc_unit_test.sv
